FILE: design/sixph_pkg.sv
// sixph_pkg: shared types, constants and helper functions of the allpass phaser
// used by sixph_divider, sixph_lane and six_stage_allpass_phaser; no dependencies
`default_nettype none
package sixph_pkg;

   localparam int unsigned DIV_LOW_W = 47;
   localparam int unsigned DIV_CNT_W = 6;

   localparam logic [17:0] DEFAULT_FS    = 18'd48000;
   localparam logic [13:0] LOW_LIMIT_HZ  = 14'd10;
   localparam logic [13:0] HIGH_LIMIT_HZ = 14'd10000;

   localparam longint unsigned TAY_C1 = 64'd1686629713;
   localparam longint unsigned TAY_C3 = 64'd693598668;
   localparam longint unsigned TAY_C5 = 64'd85569306;
   localparam longint unsigned TAY_C7 = 64'd5026995;
   localparam longint unsigned TAY_C9 = 64'd172272;

   typedef enum logic [2:0] {
      CSR_DEPTH_GAIN    = 3'd0,
      CSR_FEEDBACK_GAIN = 3'd1,
      CSR_SWEEP_LOW     = 3'd2,
      CSR_SWEEP_HIGH    = 3'd3,
      CSR_LFO_RATE      = 3'd4,
      CSR_SAMPLE_RATE   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                   start;
      logic [DIV_CNT_W-1:0]   steps;
      logic [30:0]            rem_init;
      logic [DIV_LOW_W-1:0]   low;
      logic [31:0]            divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quot;
   } div_stat_type;

   typedef struct packed {
      logic               start;
      logic signed [31:0] coef;
      logic [15:0]        fb_gain;
      logic [15:0]        depth_gain;
   } lane_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [23:0] out;
   } lane_stat_type;

   // quarter sine entry, Q0.15, evaluated at elaboration only
   function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned qlog);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned p;
      longint unsigned s;
      longint unsigned q;
      x  = (longint'(k) << 30) >> qlog;
      x2 = (x * x) >> 30;
      p  = TAY_C9;
      p  = TAY_C7 - ((x2 * p) >> 30);
      p  = TAY_C5 - ((x2 * p) >> 30);
      p  = TAY_C3 - ((x2 * p) >> 30);
      p  = TAY_C1 - ((x2 * p) >> 30);
      s  = (x * p) >> 30;
      q  = (s + 64'd16384) >> 15;
      return (q > 64'd32767) ? 15'd32767 : q[14:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) return 32'sh7fffffff;
      if (v < -40'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
      if (v > 40'sd8388607) return 24'sh7fffff;
      if (v < -40'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

endpackage
`default_nettype wire

FILE: design/sixph_divider.sv
// sixph_divider: restoring bit-serial divider, one quotient bit per cycle
// depends on sixph_pkg (command and status structs)
`default_nettype none
module sixph_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sixph_pkg::div_cmd_type cmd,
   output sixph_pkg::div_stat_type  stat
);
   import sixph_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [30:0]          rem_ff;
   logic [DIV_LOW_W-1:0] low_ff;
   logic [31:0]          div_ff;
   logic [31:0]          quot_ff;

   logic [31:0] rem_sh;
   logic        fits;

   assign rem_sh = {rem_ff, low_ff[DIV_LOW_W-1]};
   assign fits   = (rem_sh >= div_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= cmd.steps;
         rem_ff  <= cmd.rem_init;
         low_ff  <= cmd.low;
         div_ff  <= cmd.divisor;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so 31 bits hold it
         rem_ff  <= fits ? 31'(rem_sh - div_ff) : rem_sh[30:0];
         low_ff  <= {low_ff[DIV_LOW_W-2:0], 1'b0};
         quot_ff <= {quot_ff[30:0], fits};
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == DIV_CNT_W'(1));
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quot = quot_ff;

endmodule
`default_nettype wire

FILE: design/sixph_lane.sv
// sixph_lane: one audio channel, feedback sum, allpass chain and wet mix
// depends on sixph_pkg (lane structs, saturation helpers)
`default_nettype none
module sixph_lane #(
   parameter int STAGES = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sixph_pkg::lane_cmd_type cmd,
   input  wire logic signed [23:0]   sample,
   output sixph_pkg::lane_stat_type  stat
);
   import sixph_pkg::*;

   localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam logic [STG_W-1:0] LAST_STG = STG_W'(STAGES - 1);

   typedef enum logic [3:0] {
      L_IDLE, L_FB, L_SUM, L_MA, L_Y, L_MB, L_H, L_MD, L_OUT
   } lstate_type;

   lstate_type         state_ff;
   logic [STG_W-1:0]   st_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] x_ff;
   logic signed [31:0] y_ff;
   logic signed [23:0] src_ff;
   logic signed [31:0] coef_ff;
   logic signed [31:0] h_ff [STAGES];
   logic signed [31:0] fbm_ff;
   logic signed [23:0] out_ff;
   logic               done_ff;

   logic signed [63:0] r16, r18, r30;
   logic signed [31:0] h_sel;
   logic signed [31:0] sum_in, y_in, h_in;
   logic signed [23:0] out_in;

   // round half up then floor shift
   assign r16 = (prod_ff + 64'sd32768) >>> 16;
   assign r18 = (prod_ff + 64'sd131072) >>> 18;
   assign r30 = (prod_ff + 64'sd536870912) >>> 30;

   assign h_sel  = h_ff[st_ff];
   assign sum_in = sat32($signed({{11{src_ff[23]}}, src_ff, 5'b0}) + $signed(r16[39:0]));
   assign y_in   = sat32(40'(h_sel) - $signed(r30[39:0]));
   assign h_in   = sat32(40'(x_ff) + $signed(r30[39:0]));
   assign out_in = sat24(40'(src_ff) + $signed(r18[39:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
         fbm_ff   <= '0;
         for (int i = 0; i < STAGES; i++) h_ff[i] <= '0;
      end else begin
         case (state_ff)
            L_IDLE: begin
               if (cmd.start) begin
                  src_ff   <= sample;
                  coef_ff  <= cmd.coef;
                  done_ff  <= 1'b0;
                  state_ff <= L_FB;
               end
            end
            L_FB: begin
               prod_ff  <= fbm_ff * $signed({1'b0, cmd.fb_gain});
               state_ff <= L_SUM;
            end
            L_SUM: begin
               x_ff     <= sum_in;
               st_ff    <= LAST_STG;
               state_ff <= L_MA;
            end
            L_MA: begin
               prod_ff  <= coef_ff * x_ff;
               state_ff <= L_Y;
            end
            L_Y: begin
               y_ff     <= y_in;
               state_ff <= L_MB;
            end
            L_MB: begin
               prod_ff  <= coef_ff * y_ff;
               state_ff <= L_H;
            end
            L_H: begin
               h_ff[st_ff] <= h_in;
               if (st_ff == '0) begin
                  state_ff <= L_MD;
               end else begin
                  st_ff    <= st_ff - 1'b1;
                  x_ff     <= y_ff;
                  state_ff <= L_MA;
               end
            end
            L_MD: begin
               prod_ff  <= y_ff * $signed({1'b0, cmd.depth_gain});
               fbm_ff   <= y_ff;
               state_ff <= L_OUT;
            end
            L_OUT: begin
               out_ff   <= out_in;
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign stat.done = done_ff;
   assign stat.out  = out_ff;

endmodule
`default_nettype wire

FILE: design/six_stage_allpass_phaser.sv
// six_stage_allpass_phaser: stereo phaser top level, lfo, coefficient and merge
// depends on sixph_pkg, sixph_divider and sixph_lane
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_sample_left, req_sample_right
//   rsp      out        rsp_valid/rsp_ready  rsp_out_left, rsp_out_right
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// one item at a time: each result is loaded into the output register before
// the next item is accepted; the shared bit-serial divider runs 47 steps for
// the lfo increment and 30 for the allpass coefficient, then each lane steps
// through its L_MA, L_Y, L_MB and L_H states for each allpass section
// synchronous active-high reset clears config to defaults, state to zero
// a finished result waits in the output register; the next item is taken
// meanwhile and stalls only before its own result is loaded
`default_nettype none
module six_stage_allpass_phaser #(
   parameter int STAGES           = 6,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output wire logic               req_ready,
   input  wire logic signed [23:0] req_sample_left,
   input  wire logic signed [23:0] req_sample_right,
   output wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   output wire logic signed [23:0] rsp_out_left,
   output wire logic signed [23:0] rsp_out_right,
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [17:0]        csr_wdata
);
   import sixph_pkg::*;

   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int QW      = IDX_W - 2;
   localparam int QUARTER = SINE_TABLE_DEPTH / 4;

   typedef enum logic [2:0] {
      S_IDLE, S_INC, S_ROM, S_SINE, S_FREQ, S_COEF, S_LANES
   } state_type;

   // configuration registers
   logic [15:0] depth_ff;
   logic [15:0] fbgain_ff;
   logic [13:0] low_ff;
   logic [13:0] high_ff;
   logic [14:0] rate_ff;
   logic [17:0] fs_ff;

   state_type          state_ff;
   logic [31:0]        phase_ff;
   logic signed [23:0] left_ff, right_ff;
   logic [14:0]        rom_ff;
   logic               neg_ff;
   logic [29:0]        fprod_ff;
   logic               rsp_valid_ff;
   logic signed [23:0] rsp_left_ff, rsp_right_ff;

   div_cmd_type   div_cmd;
   div_stat_type  div_stat;
   lane_cmd_type  lane_cmd;
   lane_stat_type lane_l, lane_r;

   // effective config after the open-case clamps
   logic [17:0] fs_eff;
   logic [13:0] lo_c, hi_c, span;
   logic [27:0] inc_div;

   // quarter sine table
   logic [14:0]   sine_rom [0:QUARTER];
   logic [IDX_W-1:0] tab_idx;
   logic [QW:0]   rom_addr;
   logic [15:0]   u_val;

   // coefficient numerator and denominator
   logic [26:0]        f12;
   logic [29:0]        fs12;
   logic [30:0]        den;
   logic signed [31:0] num;
   logic [30:0]        mag;
   logic               num_neg_ff;
   logic signed [31:0] coef_in;

   logic accept;
   logic lanes_done;
   logic out_free;
   logic load_out;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign lanes_done = lane_l.done && lane_r.done;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_out   = (state_ff == S_LANES) && lanes_done && out_free;

   // ---- configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= 16'd8192;
         fbgain_ff <= 16'd45875;
         low_ff    <= 14'd440;
         high_ff   <= 14'd1600;
         rate_ff   <= 15'd500;
         fs_ff     <= 18'd48000;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEPTH_GAIN:    depth_ff  <= csr_wdata[15:0];
            CSR_FEEDBACK_GAIN: fbgain_ff <= csr_wdata[15:0];
            CSR_SWEEP_LOW:     low_ff    <= csr_wdata[13:0];
            CSR_SWEEP_HIGH:    high_ff   <= csr_wdata[13:0];
            CSR_LFO_RATE:      rate_ff   <= csr_wdata[14:0];
            CSR_SAMPLE_RATE:   fs_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero sample rate falls back to the default rate
   assign fs_eff = (fs_ff == '0) ? DEFAULT_FS : fs_ff;

   // lower limit clamped to its range, upper clamped up to lower and down to the high limit
   always_comb begin
      lo_c = low_ff;
      if (lo_c < LOW_LIMIT_HZ)  lo_c = LOW_LIMIT_HZ;
      if (lo_c > HIGH_LIMIT_HZ) lo_c = HIGH_LIMIT_HZ;
      hi_c = high_ff;
      if (hi_c < lo_c)          hi_c = lo_c;
      if (hi_c > HIGH_LIMIT_HZ) hi_c = HIGH_LIMIT_HZ;
   end

   assign span    = hi_c - lo_c;
   assign inc_div = 28'(fs_eff) * 28'd1000;

   // ---- sine table, built at elaboration
   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      localparam logic [14:0] ENTRY = sine_entry(g, QW);
      assign sine_rom[g] = ENTRY;
   end

   // table index from the top bits of the phase; odd quadrants mirror
   assign tab_idx  = phase_ff[31 -: IDX_W];
   assign rom_addr = tab_idx[QW] ? ((QW+1)'(QUARTER) - {1'b0, tab_idx[QW-1:0]})
                                 : {1'b0, tab_idx[QW-1:0]};

   // offset sine, always 1..65535
   assign u_val = neg_ff ? (16'd32768 - {1'b0, rom_ff}) : (16'd32768 + {1'b0, rom_ff});

   // sweep frequency in Q.12 and the allpass numerator/denominator
   assign f12  = {lo_c, 12'b0} + 27'(fprod_ff[29:4]);
   assign fs12 = {fs_eff, 12'b0};
   assign den  = 31'(fs12) + {3'b0, f12, 1'b0};
   assign num  = $signed({2'b0, fs12}) - $signed({4'b0, f12, 1'b0});
   assign mag  = num[31] ? 31'(-num) : num[30:0];

   // the coefficient division yields 30 quotient bits; higher bits are stale
   assign coef_in = num_neg_ff ? -$signed({2'b0, div_stat.quot[29:0]})
                               : $signed({2'b0, div_stat.quot[29:0]});

   // ---- divider commands: lfo increment, then allpass coefficient
   always_comb begin
      div_cmd          = '0;
      div_cmd.start    = 1'b0;
      div_cmd.steps    = DIV_CNT_W'(DIV_LOW_W);
      div_cmd.rem_init = '0;
      div_cmd.low      = {rate_ff, 32'b0};
      div_cmd.divisor  = 32'(inc_div);
      if (state_ff == S_IDLE) begin
         div_cmd.start = accept;
      end else if (state_ff == S_FREQ) begin
         // rounding half of the divisor sits in the low dividend bits
         div_cmd.start    = 1'b1;
         div_cmd.steps    = DIV_CNT_W'(30);
         div_cmd.rem_init = mag;
         div_cmd.low      = {den[30:1], 17'b0};
         div_cmd.divisor  = 32'(den);
      end
   end

   sixph_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // ---- the two channel lanes share one command
   assign lane_cmd.start      = (state_ff == S_COEF) && div_stat.done;
   assign lane_cmd.coef       = coef_in;
   assign lane_cmd.fb_gain    = fbgain_ff;
   assign lane_cmd.depth_gain = depth_ff;

   sixph_lane #(.STAGES(STAGES)) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .cmd    (lane_cmd),
      .sample (left_ff),
      .stat   (lane_l)
   );

   sixph_lane #(.STAGES(STAGES)) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .cmd    (lane_cmd),
      .sample (right_ff),
      .stat   (lane_r)
   );

   // ---- sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  left_ff  <= req_sample_left;
                  right_ff <= req_sample_right;
                  state_ff <= S_INC;
               end
            end
            S_INC: begin
               // phase advances before the sine is read
               if (div_stat.done) begin
                  phase_ff <= phase_ff + div_stat.quot;
                  state_ff <= S_ROM;
               end
            end
            S_ROM: begin
               rom_ff   <= sine_rom[rom_addr];
               neg_ff   <= tab_idx[QW+1];
               state_ff <= S_SINE;
            end
            S_SINE: begin
               fprod_ff <= 30'(span) * 30'(u_val);
               state_ff <= S_FREQ;
            end
            S_FREQ: begin
               num_neg_ff <= num[31];
               state_ff   <= S_COEF;
            end
            S_COEF: begin
               if (div_stat.done) state_ff <= S_LANES;
            end
            S_LANES: begin
               // merge: both lanes finished, result register free
               if (load_out) begin
                  rsp_left_ff  <= lane_l.out;
                  rsp_right_ff <= lane_r.out;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;

`ifndef SYNTH
   // both lanes run in lockstep
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_l.done == lane_r.done)
      else $error("channel lanes out of step");

   // the shared divider is never restarted while busy
   a_div_no_overlap: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // an accepted item closes the input until its result is loaded
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second item taken while one is in flight");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking testbench of the stereo allpass phaser
// drives frames through the valid/ready ports, predicts each output frame in
// software and compares it; depends on sixph_pkg and six_stage_allpass_phaser
`timescale 1ns / 1ps
module tb_top;
   import sixph_pkg::*;

   localparam int NSTG = 6;
   localparam int QTR = 256;
   // an index past the register list, writes to it are ignored
   localparam logic [2:0] CSR_UNUSED_IDX = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [23:0] req_sample_left = '0;
   logic signed [23:0] req_sample_right = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [23:0] rsp_out_left;
   logic signed [23:0] rsp_out_right;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [17:0] csr_wdata = '0;

   always #5 clock = ~clock;

   six_stage_allpass_phaser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_left(req_sample_left), .req_sample_right(req_sample_right),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_left(rsp_out_left), .rsp_out_right(rsp_out_right),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state: shadow registers and filter memories
   logic [15:0] m_depth, m_fb;
   logic [13:0] m_lo, m_hi;
   logic [14:0] m_rate;
   logic [17:0] m_fs;
   longint      stage_mem [2*NSTG];
   longint      fb_mem [2];
   logic [31:0] lfo_ph;
   int          qsine [QTR+1];

   logic signed [23:0] want_left [$];
   logic signed [23:0] want_right [$];
   int  fail_count = 0;
   bit  stall_mode = 0;

   function automatic longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n-1))) >>> n;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic build_sine();
      longint unsigned x, x2, p, s, q;
      for (int k = 0; k <= QTR; k++) begin
         x  = (longint'(k) << 30) / QTR;
         x2 = (x * x) >> 30;
         p  = 64'd172272;
         p  = 64'd5026995 - ((x2 * p) >> 30);
         p  = 64'd85569306 - ((x2 * p) >> 30);
         p  = 64'd693598668 - ((x2 * p) >> 30);
         p  = 64'd1686629713 - ((x2 * p) >> 30);
         s  = (x * p) >> 30;
         q  = (s + 64'd16384) >> 15;
         qsine[k] = (q > 32767) ? 32767 : int'(q);
      end
   endtask

   task automatic model_reset();
      m_depth = 8192; m_fb = 45875; m_lo = 440; m_hi = 1600;
      m_rate = 500; m_fs = 48000; lfo_ph = 0;
      foreach (stage_mem[i]) stage_mem[i] = 0;
      fb_mem[0] = 0; fb_mem[1] = 0;
   endtask

   // one frame through the phaser, queues the expected output pair
   task automatic predict_frame(logic signed [23:0] sl, logic signed [23:0] sr);
      longint unsigned fs, lo, hi, inc, u, mag, q, idx, quad, k;
      longint f12, fs12, num, den, a, src, y, x, o;
      int sv;
      logic signed [23:0] res [2];
      fs = (m_fs == 0) ? 48000 : m_fs;
      lo = m_lo;
      if (lo < 10) lo = 10;
      if (lo > 10000) lo = 10000;
      hi = m_hi;
      if (hi < lo) hi = lo;
      if (hi > 10000) hi = 10000;
      inc = (longint'(m_rate) << 32) / (1000 * fs);
      lfo_ph = lfo_ph + inc[31:0];
      idx = (longint'(lfo_ph) * (4*QTR)) >> 32;
      quad = (idx / QTR) & 3;
      k = idx % QTR;
      sv = quad[0] ? qsine[QTR - k] : qsine[k];
      if (quad[1]) sv = -sv;
      u = longint'(sv + 32768);
      f12 = (lo << 12) + (((hi - lo) * u) >> 4);
      fs12 = fs << 12;
      num = fs12 - 2*f12;
      den = fs12 + 2*f12;
      mag = (num < 0) ? -num : num;
      q = ((mag << 30) + den/2) / den;
      a = (num < 0) ? -longint'(q) : longint'(q);
      for (int ch = 0; ch < 2; ch++) begin
         src = (ch == 0) ? longint'(sl) : longint'(sr);
         y = clip32(src*32 + rnd_shift(fb_mem[ch] * longint'(m_fb), 16));
         for (int st = NSTG-1; st >= 0; st--) begin
            x = y;
            y = clip32(stage_mem[ch*NSTG+st] - rnd_shift(a * x, 30));
            stage_mem[ch*NSTG+st] = clip32(x + rnd_shift(a * y, 30));
         end
         fb_mem[ch] = y;
         o = src + rnd_shift(y * longint'(m_depth), 18);
         if (o > 8388607) o = 8388607;
         if (o < -8388608) o = -8388608;
         res[ch] = o[23:0];
      end
      want_left.insert(want_left.size(), res[0]);
      want_right.insert(want_right.size(), res[1]);
   endtask

   // send one frame; prediction happens at acceptance
   // valid stays high on return: the caller sends the next frame or idles
   task automatic send_frame(logic signed [23:0] sl, logic signed [23:0] sr);
      req_valid <= 1'b1;
      req_sample_left <= sl;
      req_sample_right <= sr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_frame(sl, sr);
   endtask

   task automatic idle(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (want_left.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [17:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_DEPTH_GAIN:    m_depth = val[15:0];
         CSR_FEEDBACK_GAIN: m_fb = val[15:0];
         CSR_SWEEP_LOW:     m_lo = val[13:0];
         CSR_SWEEP_HIGH:    m_hi = val[13:0];
         CSR_LFO_RATE:      m_rate = val[14:0];
         CSR_SAMPLE_RATE:   m_fs = val;
         default: ;
      endcase
   endtask

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 24'sh7fffff;
         1: return 24'sh800000;
         2: return $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
         default: return 24'($urandom);
      endcase
   endfunction

   // bursts of back-to-back frames with random gaps between most of them
   task automatic random_frames(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && count > 0; i++, count--)
            send_frame(rand_sample(), rand_sample());
         if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 150));
      end
   endtask

   task automatic test_directed();
      logic signed [23:0] vals [6] = '{24'sh7fffff, 24'sh800000, 24'sd0, 24'sd1,
                                       -24'sd1, 24'sh555555};
      foreach (vals[i]) send_frame(vals[i], vals[5-i]);
      // saturation with full-scale inputs at the default feedback and depth
      repeat (8) send_frame(24'sh7fffff, 24'sh800000);
      drain();
   endtask

   task automatic test_register_extremes();
      // zero sample rate falls back, sweep limits clamp, zero rate holds the lfo
      write_csr(CSR_SAMPLE_RATE, 18'd0);
      write_csr(CSR_SWEEP_LOW, 18'd0);
      write_csr(CSR_SWEEP_HIGH, 18'h3fff);
      write_csr(CSR_LFO_RATE, 18'd0);
      write_csr(CSR_DEPTH_GAIN, 18'hffff);
      write_csr(CSR_FEEDBACK_GAIN, 18'hffff);
      write_csr(csr_index_type'(CSR_UNUSED_IDX), 18'h3ffff);
      repeat (6) send_frame(rand_sample(), rand_sample());
      drain();
      // low fs so d exceeds 1, maximum lfo rate, high limit below low
      write_csr(CSR_SAMPLE_RATE, 18'd8000);
      write_csr(CSR_LFO_RATE, 18'h7fff);
      write_csr(CSR_SWEEP_LOW, 18'd10000);
      write_csr(CSR_SWEEP_HIGH, 18'd10);
      write_csr(CSR_DEPTH_GAIN, 18'd0);
      write_csr(CSR_FEEDBACK_GAIN, 18'd0);
      repeat (6) send_frame(rand_sample(), rand_sample());
      drain();
      write_csr(CSR_SAMPLE_RATE, 18'h3ffff);
      write_csr(CSR_LFO_RATE, 18'd1);
      repeat (4) send_frame(rand_sample(), rand_sample());
      drain();
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 14; ph++) begin
         write_csr(CSR_DEPTH_GAIN, 18'($urandom_range(819, 32768)));
         write_csr(CSR_FEEDBACK_GAIN, 18'($urandom_range(6554, 58982)));
         write_csr(CSR_SWEEP_LOW, 18'($urandom_range(10, 10000)));
         write_csr(CSR_SWEEP_HIGH, 18'($urandom_range(10, 10000)));
         write_csr(CSR_LFO_RATE,
                   (ph % 3 == 0) ? 18'd20000 : 18'($urandom_range(10, 20000)));
         write_csr(CSR_SAMPLE_RATE,
                   (ph % 4 == 0) ? 18'd192000 : 18'($urandom_range(8000, 192000)));
         if (ph == 5) write_csr(CSR_DEPTH_GAIN, 18'($urandom));
         stall_mode = ph[0];
         random_frames(100);
         drain();
      end
   endtask

   // receiver stall pattern: ready drops at random, more often in stall mode
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (stall_mode) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 15) != 0);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (want_left.size() == 0) begin
            $error("unexpected output item: left %0d right %0d", rsp_out_left, rsp_out_right);
            fail_count++;
         end else begin
            if (rsp_out_left !== want_left[0]) begin
               $error("out_left expected %0d got %0d", want_left[0], rsp_out_left);
               fail_count++;
            end
            if (rsp_out_right !== want_right[0]) begin
               $error("out_right expected %0d got %0d", want_right[0], rsp_out_right);
               fail_count++;
            end
            void'(want_left.pop_front());
            void'(want_right.pop_front());
         end
      end
   end

   initial begin
      build_sine();
      model_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_settings();
      drain();
      if (fail_count == 0 && want_left.size() == 0)
         $display("** six_stage_allpass_phaser: PASSED **");
      else
         $display("** six_stage_allpass_phaser: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #8ms;
      $display("** six_stage_allpass_phaser: FAILED **");
      $finish;
   end

endmodule
